### hdl/sdft_pkg.sv
`default_nettype none

package sdft_pkg;

  typedef enum logic {
    KIND_TRUNC = 1'b0,
    KIND_FLOOR = 1'b1
  } kind_t;

  // sideband that travels with each request down the chain
  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  an;   // dividend negative
    logic  bn;   // divisor negative
    logic  bz;   // divisor zero
  } side_t;

endpackage

`default_nettype wire

### hdl/sdft_prep.sv
`default_nettype none

module sdft_prep #(
  parameter int WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic               kind,
  input  wire logic [WIDTH-1:0]   dividend,
  input  wire logic [WIDTH-1:0]   divisor,
  output sdft_pkg::side_t         side_o,
  output logic [WIDTH-1:0]        am_o,
  output logic [WIDTH-1:0]        bm_o
);

  sdft_pkg::side_t  side_r, side_nxt;
  logic [WIDTH-1:0] am_r, am_nxt;
  logic [WIDTH-1:0] bm_r, bm_nxt;

  always_comb begin
    side_nxt.valid = in_valid;
    side_nxt.kind  = sdft_pkg::kind_t'(kind);
    side_nxt.an    = dividend[WIDTH-1];
    side_nxt.bn    = divisor[WIDTH-1];
    side_nxt.bz    = (divisor == '0);
    am_nxt = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
    bm_nxt = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (en) begin
      side_r <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r <= am_nxt;
      bm_r <= bm_nxt;
    end
  end

  assign side_o = side_r;
  assign am_o   = am_r;
  assign bm_o   = bm_r;

endmodule

`default_nettype wire

### hdl/sdft_cell.sv
`default_nettype none

// one restoring division step: shift in the next dividend bit, trial subtract
module sdft_cell #(
  parameter int WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire sdft_pkg::side_t    side_i,
  input  wire logic [WIDTH-1:0]   r_i,
  input  wire logic [WIDTH-1:0]   q_i,
  input  wire logic [WIDTH-1:0]   bm_i,
  output sdft_pkg::side_t         side_o,
  output logic [WIDTH-1:0]        r_o,
  output logic [WIDTH-1:0]        q_o,
  output logic [WIDTH-1:0]        bm_o
);

  sdft_pkg::side_t  side_r;
  logic [WIDTH-1:0] r_r, r_nxt;
  logic [WIDTH-1:0] q_r, q_nxt;
  logic [WIDTH-1:0] bm_r;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             ge;

  always_comb begin
    trial = {r_i, q_i[WIDTH-1]};
    diff  = trial - {1'b0, bm_i};
    ge    = ~diff[WIDTH];
    r_nxt = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    q_nxt = {q_i[WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (en) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r  <= r_nxt;
      q_r  <= q_nxt;
      bm_r <= bm_i;
    end
  end

  assign side_o = side_r;
  assign r_o    = r_r;
  assign q_o    = q_r;
  assign bm_o   = bm_r;

endmodule

`default_nettype wire

### hdl/sdft_fix.sv
`default_nettype none

// sign restore, floor correction and output register
module sdft_fix #(
  parameter int WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire sdft_pkg::side_t    side_i,
  input  wire logic [WIDTH-1:0]   rm_i,
  input  wire logic [WIDTH-1:0]   qm_i,
  input  wire logic [WIDTH-1:0]   bm_i,
  output logic                    valid_o,
  output logic [WIDTH-1:0]        quo_o,
  output logic [WIDTH-1:0]        rem_o,
  output logic                    bz_o
);

  logic             valid_r;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic             bz_r;
  logic             neg;
  logic             adj;

  always_comb begin
    neg = side_i.an ^ side_i.bn;
    adj = (side_i.kind == sdft_pkg::KIND_FLOOR) && (rm_i != '0) && neg;
    if (side_i.bz) begin
      quo_nxt = '0;
      rem_nxt = '0;
    end else begin
      if (!neg) begin
        quo_nxt = qm_i;
      end else if (adj) begin
        quo_nxt = ~qm_i;
      end else begin
        quo_nxt = ~qm_i + 1'b1;
      end
      if (adj) begin
        rem_nxt = side_i.an ? (bm_i - rm_i) : (rm_i - bm_i);
      end else if (side_i.an) begin
        rem_nxt = ~rm_i + 1'b1;
      end else begin
        rem_nxt = rm_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= side_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      bz_r  <= side_i.bz;
    end
  end

  assign valid_o = valid_r;
  assign quo_o   = quo_r;
  assign rem_o   = rem_r;
  assign bz_o    = bz_r;

endmodule

`default_nettype wire

### hdl/signed_divide_floor_truncate_unit.sv
// Signed divider giving quotient and remainder together, truncating (tuser 0) or
// flooring (tuser 1). A zero divisor returns zeros with out_tuser set; the most
// negative value over minus one wraps to the most negative quotient with remainder
// zero. Fully pipelined: one request accepted per cycle while the output side takes
// results; each request passes through the magnitude stage, a chain of WIDTH one-bit
// restoring cells and the sign-fix output register. The whole chain stalls while a
// result waits at the output.
`default_nettype none

module signed_divide_floor_truncate_unit #(
  parameter  int WIDTH  = 32,
  localparam int DATA_W = ((2 * WIDTH + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [DATA_W-1:0] in_tdata,   // dividend, divisor, zero pad
  input  wire logic              in_tuser,   // kind
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [DATA_W-1:0]      out_tdata,  // quotient, remainder, zero pad
  output logic                   out_tuser   // div_by_zero
);

  logic             en;
  sdft_pkg::side_t  side_c [0:WIDTH];
  logic [WIDTH-1:0] r_c    [0:WIDTH];
  logic [WIDTH-1:0] q_c    [0:WIDTH];
  logic [WIDTH-1:0] bm_c   [0:WIDTH];
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] rem;

  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en;
  assign r_c[0]    = '0;

  sdft_prep #(.WIDTH(WIDTH)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .kind     (in_tuser),
    .dividend (in_tdata[WIDTH-1:0]),
    .divisor  (in_tdata[2*WIDTH-1:WIDTH]),
    .side_o   (side_c[0]),
    .am_o     (q_c[0]),
    .bm_o     (bm_c[0])
  );

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    sdft_cell #(.WIDTH(WIDTH)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .side_i (side_c[i]),
      .r_i    (r_c[i]),
      .q_i    (q_c[i]),
      .bm_i   (bm_c[i]),
      .side_o (side_c[i+1]),
      .r_o    (r_c[i+1]),
      .q_o    (q_c[i+1]),
      .bm_o   (bm_c[i+1])
    );
  end

  sdft_fix #(.WIDTH(WIDTH)) u_fix (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .side_i  (side_c[WIDTH]),
    .rm_i    (r_c[WIDTH]),
    .qm_i    (q_c[WIDTH]),
    .bm_i    (bm_c[WIDTH]),
    .valid_o (out_tvalid),
    .quo_o   (quo),
    .rem_o   (rem),
    .bz_o    (out_tuser)
  );

  assign out_tdata = DATA_W'({rem, quo});

  a_prep_zero_flag : assert property (@(posedge clk) disable iff (!rst_n)
    side_c[0].valid |-> ((bm_c[0] == '0) == side_c[0].bz))
    else $error("divisor-zero flag disagrees with divisor magnitude");

  a_rem_below_divisor : assert property (@(posedge clk) disable iff (!rst_n)
    (side_c[WIDTH].valid && !side_c[WIDTH].bz) |-> (r_c[WIDTH] < bm_c[WIDTH]))
    else $error("partial remainder not below divisor at end of chain");

  a_zero_div_results : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (quo == '0 && rem == '0))
    else $error("non-zero results on divide by zero");

endmodule

`default_nettype wire

### dv/tb_signed_divide_floor_truncate_unit.sv
`timescale 1ns / 1ps

module tb_signed_divide_floor_truncate_unit;

  localparam int WIDTH          = 32;
  localparam int DATA_W         = ((2 * WIDTH + 7) / 8) * 8;
  localparam int LATENCY        = WIDTH + 2;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int CYCLE_LIMIT    = 400000;

  localparam logic [WIDTH-1:0] MOST_NEG  = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] MOST_POS  = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic [WIDTH-1:0] MINUS_ONE = {WIDTH{1'b1}};

  typedef struct packed {
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
    logic             div_by_zero;
  } quot_rem_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;
  logic              in_tuser   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tuser;

  quot_rem_t pending_quot_rem[$];
  int        mismatches     = 0;
  int        cycle_count    = 0;
  int        sender_idle    = 0;
  int        receiver_stall = 0;
  int        holdoff_token  = 0;
  int        holdoff_seen   = 0;
  int        holdoff_left   = 0;

  signed_divide_floor_truncate_unit #(.WIDTH(WIDTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout, %0d requests outstanding", $time, pending_quot_rem.size());
      $display("FAILURE");
      $finish;
    end
  end

  // result-side ready; a token change starts a long hold-off
  always @(posedge clk) begin
    if (holdoff_token != holdoff_seen) begin
      holdoff_seen <= holdoff_token;
      holdoff_left <= HOLDOFF_CYCLES;
      out_tready   <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= receiver_stall);
    end
  end

  function automatic quot_rem_t predict_quot_rem(sdft_pkg::kind_t kind, logic [WIDTH-1:0] a,
                                                 logic [WIDTH-1:0] b);
    quot_rem_t res;
    logic      an, bn;
    logic [WIDTH:0] am, bm, qm, rm, q, r;
    res = '0;
    if (b == '0) begin
      res.div_by_zero = 1'b1;
      return res;
    end
    an = a[WIDTH-1];
    bn = b[WIDTH-1];
    am = an ? ({1'b0, ~a} + 1'b1) : {1'b0, a};
    bm = bn ? ({1'b0, ~b} + 1'b1) : {1'b0, b};
    qm = am / bm;
    rm = am % bm;
    q  = (an != bn) ? -qm : qm;
    r  = an ? -rm : rm;
    if (kind == sdft_pkg::KIND_FLOOR && rm != '0 && an != bn) begin
      q = q - 1'b1;
      r = r + {1'b0, b};
    end
    res.quotient  = q[WIDTH-1:0];
    res.remainder = r[WIDTH-1:0];
    return res;
  endfunction

  always @(negedge clk) begin
    quot_rem_t want;
    logic [WIDTH-1:0] got_q, got_r;
    if (rst_n && out_tvalid && out_tready) begin
      got_q = out_tdata[WIDTH-1:0];
      got_r = out_tdata[2*WIDTH-1:WIDTH];
      if (pending_quot_rem.size() == 0) begin
        $display("%0t unexpected result: expected none got q=%0d r=%0d dbz=%0b",
                 $time, $signed(got_q), $signed(got_r), out_tuser);
        mismatches++;
      end else begin
        want = pending_quot_rem.pop_front();
        if (got_q !== want.quotient) begin
          $display("%0t quotient: expected %0d got %0d", $time,
                   $signed(want.quotient), $signed(got_q));
          mismatches++;
        end
        if (got_r !== want.remainder) begin
          $display("%0t remainder: expected %0d got %0d", $time,
                   $signed(want.remainder), $signed(got_r));
          mismatches++;
        end
        if (out_tuser !== want.div_by_zero) begin
          $display("%0t div_by_zero: expected %0b got %0b", $time,
                   want.div_by_zero, out_tuser);
          mismatches++;
        end
      end
    end
  end

  // called at a rising edge; returns at the edge that takes the request
  task automatic send_division(sdft_pkg::kind_t kind, logic [WIDTH-1:0] a,
                               logic [WIDTH-1:0] b);
    while ($urandom_range(0, 99) < sender_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_W'({b, a});
    in_tuser  <= kind;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    pending_quot_rem.push_back(predict_quot_rem(kind, a, b));
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_quot_rem.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WIDTH-1:0] pick_operand();
    logic [WIDTH-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = WIDTH'($urandom_range(0, 15));
      1:       v = ~WIDTH'($urandom_range(0, 15));
      2:       v = MOST_NEG | WIDTH'($urandom_range(0, 3));
      3:       v = MOST_POS - WIDTH'($urandom_range(0, 3));
      4:       v = WIDTH'($urandom >> $urandom_range(0, WIDTH - 1));
      5:       v = ~WIDTH'($urandom >> $urandom_range(0, WIDTH - 1));
      default: v = WIDTH'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_random_division();
    logic [WIDTH-1:0] a, b;
    int sel;
    a   = pick_operand();
    b   = pick_operand();
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      b = '0;
    end else if (sel < 7) begin
      a = MOST_NEG;
      b = MINUS_ONE;
    end else if (sel < 17) begin
      b = (b == '0) ? MINUS_ONE : b;
      a = b * WIDTH'($signed($urandom_range(0, 200)) - 100);
    end
    send_division(sdft_pkg::kind_t'($urandom_range(0, 1)), a, b);
  endtask

  task automatic run_random(int count, int idle_pct, int stall_pct);
    sender_idle    = idle_pct;
    receiver_stall = stall_pct;
    repeat (count) send_random_division();
  endtask

  task automatic test_directed_corners();
    logic [WIDTH-1:0] dividends[12];
    logic [WIDTH-1:0] divisors[12];
    dividends = '{MOST_NEG, 32'd7, -32'sd7, 32'd7, -32'sd7, 32'd6, 32'd1, MINUS_ONE,
                  MOST_POS, MOST_NEG, MOST_POS, 32'd0};
    divisors  = '{MINUS_ONE, 32'd2, 32'd2, -32'sd2, -32'sd2, -32'sd3, MOST_NEG,
                  MOST_POS, MOST_NEG, MOST_NEG, 32'd0, 32'd0};
    sender_idle    = 0;
    receiver_stall = 0;
    for (int i = 0; i < 12; i++) begin
      send_division(sdft_pkg::KIND_TRUNC, dividends[i], divisors[i]);
      send_division(sdft_pkg::KIND_FLOOR, dividends[i], divisors[i]);
    end
    send_division(sdft_pkg::KIND_FLOOR, MOST_NEG, 32'd1);
    wait_drained();
  endtask

  task automatic test_random_no_idle();
    run_random(300, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    run_random(300, 79, 0);
  endtask

  task automatic test_random_receiver_stall();
    run_random(300, 0, 79);
  endtask

  task automatic test_random_both_idle();
    run_random(300, 38, 38);
  endtask

  // outputs held off long enough for the pipe to fill and stall the input
  task automatic test_output_backpressure();
    receiver_stall = 0;
    holdoff_token  = holdoff_token + 1;
    run_random(150, 0, 0);
  endtask

  task automatic test_pause_until_drained();
    repeat (5) begin
      wait_drained();
      @(posedge clk);
      run_random(50, $urandom_range(0, 50), $urandom_range(0, 50));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_output_backpressure();
    test_pause_until_drained();
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && pending_quot_rem.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### signed_divide_floor_truncate_unit.f
hdl/sdft_pkg.sv
hdl/sdft_prep.sv
hdl/sdft_cell.sv
hdl/sdft_fix.sv
hdl/signed_divide_floor_truncate_unit.sv
dv/tb_signed_divide_floor_truncate_unit.sv
